/* rtl/e2q_pkg.sv */
package e2q_pkg;

    localparam int ANGLE_W    = 16;
    localparam int COMP_W     = 16;
    localparam int FRAC       = 30;
    localparam int NUM_STAGES = 22;

    // first stage of each section of the pipeline
    localparam int PREP_BASE = 0;
    localparam int SC_BASE   = 6;
    localparam int QUAT_BASE = 17;

    // half angle units (1/128 degree)
    localparam logic [16:0] TURN_UNITS    = 17'd46080;
    localparam logic [15:0] QUARTER_UNITS = 16'd11520;
    localparam logic [15:0] HALF_UNITS    = 16'd23040;
    localparam logic [15:0] THREEQ_UNITS  = 16'd34560;
    localparam logic [13:0] QUARTER_REM   = 14'd11520;
    localparam logic [13:0] EIGHTH_REM    = 14'd5760;

    // radians = u * pi / 23040 split as u * A + (u * B + 11520) / 23040
    localparam logic [17:0] RAD_A      = 18'd146408;
    localparam logic [14:0] RAD_B      = 15'd19106;
    localparam logic [13:0] RAD_HALF   = 14'd11520;
    localparam logic [18:0] RECIP45    = 19'd372828;
    localparam int          RECIP45_SH = 24;

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam int SIN_STEPS = 4;
    localparam int COS_STEPS = 5;
    localparam int COS_FIRST = 4;
    localparam int HORNER_STEPS = SIN_STEPS + COS_STEPS;

    // divisor n = 2^sh * d, 1/d by multiply with m and shift by k
    localparam logic [6:0] HORNER_N [HORNER_STEPS] =
        '{7'd72, 7'd42, 7'd20, 7'd6, 7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [1:0] HORNER_SH [HORNER_STEPS] =
        '{2'd3, 2'd1, 2'd2, 2'd1, 2'd1, 2'd3, 2'd1, 2'd2, 2'd1};
    localparam logic [29:0] HORNER_M [HORNER_STEPS] =
        '{30'd238609295, 30'd818089009, 30'd429496730, 30'd715827883,
          30'd763549742, 30'd153391690, 30'd572662307, 30'd357913942, 30'd1};
    localparam logic [5:0] HORNER_K [HORNER_STEPS] =
        '{6'd31, 6'd34, 6'd31, 6'd31, 6'd35, 6'd30, 6'd33, 6'd30, 6'd0};

    localparam int COMP_SH = 61 - COMP_W;

    typedef logic [FRAC:0]          q30u_t;
    typedef logic [FRAC-1:0]        rad_t;
    typedef logic signed [31:0]     q30s_t;
    typedef logic [NUM_STAGES-1:0]  stage_en_t;

    localparam q30u_t ONE_Q = q30u_t'(1) << FRAC;

    typedef struct packed {
        logic [1:0] quad;
        logic       swap;
    } fold_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } angles_t;

    typedef struct packed {
        logic signed [COMP_W-1:0] quat_w;
        logic signed [COMP_W-1:0] quat_x;
        logic signed [COMP_W-1:0] quat_y;
        logic signed [COMP_W-1:0] quat_z;
    } quat_t;

    // r2 * t / 2^30 plus half the divisor, first half of a horner step
    function automatic q30u_t horner_mul(input rad_t r2, input q30u_t t,
                                         input logic [3:0] idx);
        logic [61:0] acc;
        acc = 62'(r2) * 62'(t) + (62'(HORNER_N[idx]) << (FRAC - 1));
        return acc[FRAC +: FRAC + 1];
    endfunction

    // 2^30 - p / n, second half of a horner step
    function automatic q30u_t horner_div(input q30u_t p, input logic [3:0] idx);
        q30u_t       z;
        logic [60:0] prod;
        z    = p >> HORNER_SH[idx];
        prod = 61'(z) * 61'(HORNER_M[idx]);
        return ONE_Q - q30u_t'(prod >> HORNER_K[idx]);
    endfunction

    // q30 product, rounded half away from zero
    function automatic q30s_t mul_q30(input q30s_t a, input q30s_t b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] prod;
        logic [31:0] m;
        ma   = a[31] ? 32'(-a) : 32'(a);
        mb   = b[31] ? 32'(-b) : 32'(b);
        prod = 64'(ma) * 64'(mb) + (64'd1 << (FRAC - 1));
        m    = prod[FRAC +: 32];
        return (a[31] ^ b[31]) ? -q30s_t'(m) : q30s_t'(m);
    endfunction

endpackage

/* rtl/euler_to_quaternion.sv */
// ZYX Euler angle to unit quaternion converter. Roll, pitch and yaw arrive in one
// transaction as signed 1/64 degree values; any 16-bit pattern is valid and is taken
// modulo a full turn of the half angle. Each half angle is folded into one octant,
// turned into radians and run through fixed-point sine and cosine polynomials, and
// the four components w, x, y, z leave as saturated signed Q1.15. The datapath is a
// 22-stage pipeline with a valid bit per stage: one transaction can enter every
// cycle while the output is not held off, and m_valid is the valid bit of the last
// stage. A stage holds only when it and every stage after it are full, so bubbles
// close up while a finished result waits on m_ready; s_ready follows m_ready
// combinationally through that chain. Nothing is dropped or repeated.
// The block holds no other state, and reset only clears the valid bits.
module euler_to_quaternion (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  e2q_pkg::angles_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output e2q_pkg::quat_t   m_data
);

    logic [e2q_pkg::NUM_STAGES-1:0] valid_reg;
    logic [e2q_pkg::NUM_STAGES-1:0] valid_next;
    e2q_pkg::stage_en_t             en;

    e2q_pkg::rad_t   rad_r, rad_p, rad_y;
    e2q_pkg::rad_t   sq_r, sq_p, sq_y;
    e2q_pkg::fold_t  fold_r, fold_p, fold_y;
    e2q_pkg::q30s_t  sin_r, cos_r, sin_p, cos_p, sin_y, cos_y;

    // a stage may load when it is empty or when the stage after it moves on
    for (genvar i = 0; i < e2q_pkg::NUM_STAGES; i++) begin : g_en
        if (i == e2q_pkg::NUM_STAGES - 1) begin : g_last
            assign en[i] = !valid_reg[i] || m_ready;
        end else begin : g_mid
            assign en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb begin
        valid_next[0] = en[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < e2q_pkg::NUM_STAGES; i++) begin
            valid_next[i] = en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // angle reduction and radian conversion, one per axis
    e2q_angle_prep u_prep_roll (
        .aclk   (aclk),
        .en     (en),
        .angle  (s_data.roll_angle),
        .rad    (rad_r),
        .rad_sq (sq_r),
        .fold   (fold_r)
    );

    e2q_angle_prep u_prep_pitch (
        .aclk   (aclk),
        .en     (en),
        .angle  (s_data.pitch_angle),
        .rad    (rad_p),
        .rad_sq (sq_p),
        .fold   (fold_p)
    );

    e2q_angle_prep u_prep_yaw (
        .aclk   (aclk),
        .en     (en),
        .angle  (s_data.yaw_angle),
        .rad    (rad_y),
        .rad_sq (sq_y),
        .fold   (fold_y)
    );

    // half angle sine and cosine polynomials
    e2q_sincos u_sc_roll (
        .aclk     (aclk),
        .en       (en),
        .rad      (rad_r),
        .rad_sq   (sq_r),
        .fold     (fold_r),
        .sin_half (sin_r),
        .cos_half (cos_r)
    );

    e2q_sincos u_sc_pitch (
        .aclk     (aclk),
        .en       (en),
        .rad      (rad_p),
        .rad_sq   (sq_p),
        .fold     (fold_p),
        .sin_half (sin_p),
        .cos_half (cos_p)
    );

    e2q_sincos u_sc_yaw (
        .aclk     (aclk),
        .en       (en),
        .rad      (rad_y),
        .rad_sq   (sq_y),
        .fold     (fold_y),
        .sin_half (sin_y),
        .cos_half (cos_y)
    );

    // zyx products, rounding and saturation; last stage is the output register
    e2q_quat u_quat (
        .aclk  (aclk),
        .en    (en),
        .sin_r (sin_r),
        .cos_r (cos_r),
        .sin_p (sin_p),
        .cos_p (cos_p),
        .sin_y (sin_y),
        .cos_y (cos_y),
        .quat  (m_data)
    );

    assign s_ready = en[0];
    assign m_valid = valid_reg[e2q_pkg::NUM_STAGES-1];

endmodule

/* rtl/e2q_angle_prep.sv */
module e2q_angle_prep (
    input  logic                                aclk,
    input  e2q_pkg::stage_en_t                  en,
    input  logic signed [e2q_pkg::ANGLE_W-1:0]  angle,
    output e2q_pkg::rad_t                       rad,
    output e2q_pkg::rad_t                       rad_sq,
    output e2q_pkg::fold_t                      fold
);

    logic [16:0]          wrap_sum;
    logic [15:0]          unit_next;
    logic [15:0]          unit_reg;
    logic [1:0]           quad;
    logic [15:0]          quad_base;
    logic [13:0]          rem;
    logic                 swap;
    logic [12:0]          oct_next;
    logic [12:0]          oct_reg;
    logic [30:0]          ua_prod;
    logic [29:0]          ua_reg;
    logic [29:0]          ua2_reg;
    logic [26:0]          yb_reg;
    logic [17:0]          yb_hi;
    logic [36:0]          corr_prod;
    logic [12:0]          corr_reg;
    e2q_pkg::rad_t        rad5_reg;
    e2q_pkg::rad_t        rad6_reg;
    e2q_pkg::rad_t        rad_sq_reg;
    logic [59:0]          sq_acc;
    e2q_pkg::fold_t       fold_reg [5];

    // one turn of the half angle is added to negative inputs
    assign wrap_sum  = 17'(angle) + e2q_pkg::TURN_UNITS;
    assign unit_next = angle[e2q_pkg::ANGLE_W-1] ? wrap_sum[15:0] : $unsigned(angle);

    always_comb begin
        if (unit_reg >= e2q_pkg::THREEQ_UNITS) begin
            quad      = e2q_pkg::QUAD_3;
            quad_base = e2q_pkg::THREEQ_UNITS;
        end else if (unit_reg >= e2q_pkg::HALF_UNITS) begin
            quad      = e2q_pkg::QUAD_2;
            quad_base = e2q_pkg::HALF_UNITS;
        end else if (unit_reg >= e2q_pkg::QUARTER_UNITS) begin
            quad      = e2q_pkg::QUAD_1;
            quad_base = e2q_pkg::QUARTER_UNITS;
        end else begin
            quad      = e2q_pkg::QUAD_0;
            quad_base = 16'd0;
        end
        rem      = 14'(unit_reg - quad_base);
        swap     = rem > e2q_pkg::EIGHTH_REM;
        oct_next = swap ? 13'(e2q_pkg::QUARTER_REM - rem) : 13'(rem);
    end

    assign ua_prod   = 31'(oct_reg) * 31'(e2q_pkg::RAD_A);
    assign yb_hi     = yb_reg[26:9];
    assign corr_prod = 37'(yb_hi) * 37'(e2q_pkg::RECIP45);
    assign sq_acc    = 60'(rad5_reg) * 60'(rad5_reg) + (60'd1 << (e2q_pkg::FRAC - 1));

    always_ff @(posedge aclk) begin
        if (en[e2q_pkg::PREP_BASE]) begin
            unit_reg <= unit_next;
        end
        if (en[e2q_pkg::PREP_BASE + 1]) begin
            oct_reg          <= oct_next;
            fold_reg[0].quad <= quad;
            fold_reg[0].swap <= swap;
        end
        if (en[e2q_pkg::PREP_BASE + 2]) begin
            ua_reg      <= ua_prod[29:0];
            yb_reg      <= 27'(27'(oct_reg) * 27'(e2q_pkg::RAD_B) + 27'(e2q_pkg::RAD_HALF));
            fold_reg[1] <= fold_reg[0];
        end
        if (en[e2q_pkg::PREP_BASE + 3]) begin
            ua2_reg     <= ua_reg;
            corr_reg    <= corr_prod[e2q_pkg::RECIP45_SH +: 13];
            fold_reg[2] <= fold_reg[1];
        end
        if (en[e2q_pkg::PREP_BASE + 4]) begin
            rad5_reg    <= ua2_reg + 30'(corr_reg);
            fold_reg[3] <= fold_reg[2];
        end
        if (en[e2q_pkg::PREP_BASE + 5]) begin
            rad6_reg    <= rad5_reg;
            rad_sq_reg  <= sq_acc[e2q_pkg::FRAC +: e2q_pkg::FRAC];
            fold_reg[4] <= fold_reg[3];
        end
    end

    assign rad    = rad6_reg;
    assign rad_sq = rad_sq_reg;
    assign fold   = fold_reg[4];

endmodule

/* rtl/e2q_sincos.sv */
module e2q_sincos (
    input  logic               aclk,
    input  e2q_pkg::stage_en_t en,
    input  e2q_pkg::rad_t      rad,
    input  e2q_pkg::rad_t      rad_sq,
    input  e2q_pkg::fold_t     fold,
    output e2q_pkg::q30s_t     sin_half,
    output e2q_pkg::q30s_t     cos_half
);

    e2q_pkg::rad_t   rad_sq_reg [8];
    e2q_pkg::rad_t   rad_reg    [8];
    e2q_pkg::fold_t  fold_reg   [10];
    e2q_pkg::q30u_t  sin_p_reg  [e2q_pkg::SIN_STEPS];
    e2q_pkg::q30u_t  sin_t_reg  [e2q_pkg::SIN_STEPS];
    e2q_pkg::q30u_t  cos_p_reg  [e2q_pkg::COS_STEPS];
    e2q_pkg::q30u_t  cos_t_reg  [e2q_pkg::COS_STEPS];
    e2q_pkg::q30u_t  sin_t_src  [e2q_pkg::SIN_STEPS];
    e2q_pkg::q30u_t  cos_t_src  [e2q_pkg::COS_STEPS];
    e2q_pkg::rad_t   sq_src     [e2q_pkg::COS_STEPS];
    logic [61:0]     sin_acc;
    e2q_pkg::q30u_t  sin_q_reg;
    e2q_pkg::q30u_t  sin_d_reg;
    e2q_pkg::q30s_t  s0;
    e2q_pkg::q30s_t  c0;
    e2q_pkg::q30s_t  sin_next;
    e2q_pkg::q30s_t  cos_next;
    e2q_pkg::q30s_t  sin_reg;
    e2q_pkg::q30s_t  cos_reg;

    // delay lines for r, r squared and the fold code
    for (genvar k = 0; k < 8; k++) begin : g_rad_dly
        if (k == 0) begin : g_head
            always_ff @(posedge aclk) begin
                if (en[e2q_pkg::SC_BASE]) begin
                    rad_sq_reg[0] <= rad_sq;
                    rad_reg[0]    <= rad;
                end
            end
        end else begin : g_tail
            always_ff @(posedge aclk) begin
                if (en[e2q_pkg::SC_BASE + k]) begin
                    rad_sq_reg[k] <= rad_sq_reg[k-1];
                    rad_reg[k]    <= rad_reg[k-1];
                end
            end
        end
    end

    for (genvar k = 0; k < 10; k++) begin : g_fold_dly
        if (k == 0) begin : g_head
            always_ff @(posedge aclk) begin
                if (en[e2q_pkg::SC_BASE]) begin
                    fold_reg[0] <= fold;
                end
            end
        end else begin : g_tail
            always_ff @(posedge aclk) begin
                if (en[e2q_pkg::SC_BASE + k]) begin
                    fold_reg[k] <= fold_reg[k-1];
                end
            end
        end
    end

    // horner steps, two stages each
    for (genvar j = 0; j < e2q_pkg::COS_STEPS; j++) begin : g_src
        if (j == 0) begin : g_head
            assign sq_src[0]    = rad_sq;
            assign cos_t_src[0] = e2q_pkg::ONE_Q;
        end else begin : g_tail
            assign sq_src[j]    = rad_sq_reg[2*j-1];
            assign cos_t_src[j] = cos_t_reg[j-1];
        end
    end

    for (genvar j = 0; j < e2q_pkg::SIN_STEPS; j++) begin : g_sin
        if (j == 0) begin : g_head
            assign sin_t_src[0] = e2q_pkg::ONE_Q;
        end else begin : g_tail
            assign sin_t_src[j] = sin_t_reg[j-1];
        end
        always_ff @(posedge aclk) begin
            if (en[e2q_pkg::SC_BASE + 2*j]) begin
                sin_p_reg[j] <= e2q_pkg::horner_mul(sq_src[j], sin_t_src[j], 4'(j));
            end
            if (en[e2q_pkg::SC_BASE + 2*j + 1]) begin
                sin_t_reg[j] <= e2q_pkg::horner_div(sin_p_reg[j], 4'(j));
            end
        end
    end

    for (genvar j = 0; j < e2q_pkg::COS_STEPS; j++) begin : g_cos
        always_ff @(posedge aclk) begin
            if (en[e2q_pkg::SC_BASE + 2*j]) begin
                cos_p_reg[j] <= e2q_pkg::horner_mul(sq_src[j], cos_t_src[j],
                                                    4'(e2q_pkg::COS_FIRST + j));
            end
            if (en[e2q_pkg::SC_BASE + 2*j + 1]) begin
                cos_t_reg[j] <= e2q_pkg::horner_div(cos_p_reg[j],
                                                    4'(e2q_pkg::COS_FIRST + j));
            end
        end
    end

    assign sin_acc = 62'(rad_reg[7]) * 62'(sin_t_reg[e2q_pkg::SIN_STEPS-1])
                   + (62'd1 << (e2q_pkg::FRAC - 1));

    // undo the octant fold and the quadrant split
    always_comb begin
        s0 = fold_reg[9].swap ? 32'(cos_t_reg[e2q_pkg::COS_STEPS-1]) : 32'(sin_d_reg);
        c0 = fold_reg[9].swap ? 32'(sin_d_reg) : 32'(cos_t_reg[e2q_pkg::COS_STEPS-1]);
        case (fold_reg[9].quad)
            e2q_pkg::QUAD_0: begin
                sin_next = s0;
                cos_next = c0;
            end
            e2q_pkg::QUAD_1: begin
                sin_next = c0;
                cos_next = -s0;
            end
            e2q_pkg::QUAD_2: begin
                sin_next = -s0;
                cos_next = -c0;
            end
            default: begin
                sin_next = -c0;
                cos_next = s0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[e2q_pkg::SC_BASE + 8]) begin
            sin_q_reg <= sin_acc[e2q_pkg::FRAC +: e2q_pkg::FRAC + 1];
        end
        if (en[e2q_pkg::SC_BASE + 9]) begin
            sin_d_reg <= sin_q_reg;
        end
        if (en[e2q_pkg::SC_BASE + 10]) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_half = sin_reg;
    assign cos_half = cos_reg;

endmodule

/* rtl/e2q_quat.sv */
module e2q_quat (
    input  logic               aclk,
    input  e2q_pkg::stage_en_t en,
    input  e2q_pkg::q30s_t     sin_r,
    input  e2q_pkg::q30s_t     cos_r,
    input  e2q_pkg::q30s_t     sin_p,
    input  e2q_pkg::q30s_t     cos_p,
    input  e2q_pkg::q30s_t     sin_y,
    input  e2q_pkg::q30s_t     cos_y,
    output e2q_pkg::quat_t     quat
);

    localparam logic [63:0] COMP_LIM = (64'd1 << (e2q_pkg::COMP_W - 1)) - 64'd1;

    e2q_pkg::q30s_t     pair_cc_reg;
    e2q_pkg::q30s_t     pair_ss_reg;
    e2q_pkg::q30s_t     pair_sc_reg;
    e2q_pkg::q30s_t     pair_cs_reg;
    e2q_pkg::q30s_t     sin_y_reg;
    e2q_pkg::q30s_t     cos_y_reg;
    logic signed [63:0] trip_reg [8];
    logic signed [63:0] sum_reg  [4];
    logic [63:0]        mag_reg  [4];
    logic               neg_reg  [4];
    logic signed [e2q_pkg::COMP_W-1:0] comp_next [4];
    e2q_pkg::quat_t     quat_reg;

    // round to the output format and clamp below one
    function automatic logic signed [e2q_pkg::COMP_W-1:0] to_comp(input logic [63:0] mag,
                                                                  input logic neg);
        logic [63:0]                 rnd;
        logic [63:0]                 full;
        logic [e2q_pkg::COMP_W-1:0]  sat;
        rnd  = mag + (64'd1 << (e2q_pkg::COMP_SH - 1));
        full = rnd >> e2q_pkg::COMP_SH;
        sat  = (full > COMP_LIM) ? COMP_LIM[e2q_pkg::COMP_W-1:0]
                                 : full[e2q_pkg::COMP_W-1:0];
        return neg ? -$signed(sat) : $signed(sat);
    endfunction

    for (genvar i = 0; i < 4; i++) begin : g_comp
        assign comp_next[i] = to_comp(mag_reg[i], neg_reg[i]);
    end

    always_ff @(posedge aclk) begin
        if (en[e2q_pkg::QUAT_BASE]) begin
            pair_cc_reg <= e2q_pkg::mul_q30(cos_r, cos_p);
            pair_ss_reg <= e2q_pkg::mul_q30(sin_r, sin_p);
            pair_sc_reg <= e2q_pkg::mul_q30(sin_r, cos_p);
            pair_cs_reg <= e2q_pkg::mul_q30(cos_r, sin_p);
            sin_y_reg   <= sin_y;
            cos_y_reg   <= cos_y;
        end
        if (en[e2q_pkg::QUAT_BASE + 1]) begin
            trip_reg[0] <= 64'(pair_cc_reg) * 64'(cos_y_reg);
            trip_reg[1] <= 64'(pair_ss_reg) * 64'(sin_y_reg);
            trip_reg[2] <= 64'(pair_sc_reg) * 64'(cos_y_reg);
            trip_reg[3] <= 64'(pair_cs_reg) * 64'(sin_y_reg);
            trip_reg[4] <= 64'(pair_cs_reg) * 64'(cos_y_reg);
            trip_reg[5] <= 64'(pair_sc_reg) * 64'(sin_y_reg);
            trip_reg[6] <= 64'(pair_cc_reg) * 64'(sin_y_reg);
            trip_reg[7] <= 64'(pair_ss_reg) * 64'(cos_y_reg);
        end
        if (en[e2q_pkg::QUAT_BASE + 2]) begin
            sum_reg[0] <= trip_reg[0] + trip_reg[1];
            sum_reg[1] <= trip_reg[2] - trip_reg[3];
            sum_reg[2] <= trip_reg[4] + trip_reg[5];
            sum_reg[3] <= trip_reg[6] - trip_reg[7];
        end
        if (en[e2q_pkg::QUAT_BASE + 3]) begin
            for (int i = 0; i < 4; i++) begin
                mag_reg[i] <= sum_reg[i][63] ? 64'(-sum_reg[i]) : 64'(sum_reg[i]);
                neg_reg[i] <= sum_reg[i][63];
            end
        end
        if (en[e2q_pkg::QUAT_BASE + 4]) begin
            quat_reg.quat_w <= comp_next[0];
            quat_reg.quat_x <= comp_next[1];
            quat_reg.quat_y <= comp_next[2];
            quat_reg.quat_z <= comp_next[3];
        end
    end

    assign quat = quat_reg;

endmodule
